// ----- hdl/ame_pkg.sv -----
// ----------------------------------------------------------------------------
// ame_pkg
// Shared types and opcodes of the accumulator machine execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ame_pkg;

  localparam int CMD_W     = 7;
  localparam int OPERAND_W = 5;
  localparam int IO_WORD_W = 32;
  localparam int PC_W      = 6;

  // opcodes
  localparam logic [CMD_W-1:0] OP_READ  = 7'd10;
  localparam logic [CMD_W-1:0] OP_WRITE = 7'd11;
  localparam logic [CMD_W-1:0] OP_LOAD  = 7'd20;
  localparam logic [CMD_W-1:0] OP_STORE = 7'd21;
  localparam logic [CMD_W-1:0] OP_ADD   = 7'd30;
  localparam logic [CMD_W-1:0] OP_SUB   = 7'd31;
  localparam logic [CMD_W-1:0] OP_DIV   = 7'd32;
  localparam logic [CMD_W-1:0] OP_MUL   = 7'd33;
  localparam logic [CMD_W-1:0] OP_JUMP  = 7'd40;
  localparam logic [CMD_W-1:0] OP_JNEG  = 7'd41;
  localparam logic [CMD_W-1:0] OP_JZERO = 7'd42;
  localparam logic [CMD_W-1:0] OP_HALT  = 7'd43;

  // register index of program_length (byte address = 4 * index)
  localparam logic REG_PROGRAM_LENGTH = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]            command;
    logic [OPERAND_W-1:0]        operand;
    logic signed [IO_WORD_W-1:0] read_value;
  } ame_in_t;

  typedef struct packed {
    logic                        write_valid;
    logic signed [IO_WORD_W-1:0] write_value;
    logic [PC_W-1:0]             next_pc;
    logic                        halted;
    logic                        divide_error;
  } ame_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch item, issue memory read
    logic start;   // launch multiply/divide
    logic commit;  // update state, load output register
  } ame_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_md;
    logic md_done;
  } ame_sts_t;

endpackage

`default_nettype wire

// ----- hdl/ame_ram.sv -----
// ----------------------------------------------------------------------------
// ame_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ame_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/ame_muldiv.sv -----
// ----------------------------------------------------------------------------
// ame_muldiv
// Iterative radix-2 multiplier (low word) and signed restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ame_muldiv #(
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  is_div,
  input  wire logic [WORD_WIDTH-1:0] op_a,
  input  wire logic [WORD_WIDTH-1:0] op_b,
  output logic      [WORD_WIDTH-1:0] result,
  output logic                       done
);

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  x_r, x_nxt;   // product / quotient
  logic [W-1:0]  y_r, y_nxt;   // multiplicand / divisor magnitude
  logic [W-1:0]  r_r, r_nxt;   // multiplier / remainder
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          div_r, neg_r, done_r, done_nxt;
  logic [W:0]    trial;
  logic [W-1:0]  mag_a, mag_b;

  assign mag_a = op_a[W-1] ? (~op_a + 1'b1) : op_a;
  assign mag_b = op_b[W-1] ? (~op_b + 1'b1) : op_b;
  assign trial = {r_r, x_r[W-1]} - {1'b0, y_r};

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (cnt_r != '0) begin
      if (div_r) begin
        if (!trial[W]) begin
          r_nxt = trial[W-1:0];
          x_nxt = {x_r[W-2:0], 1'b1};
        end else begin
          r_nxt = {r_r[W-2:0], x_r[W-1]};
          x_nxt = {x_r[W-2:0], 1'b0};
        end
      end else begin
        if (r_r[0]) begin
          x_nxt = x_r + y_r;
        end
        y_nxt = {y_r[W-2:0], 1'b0};
        r_nxt = {1'b0, r_r[W-1:1]};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(W);
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= is_div;
      neg_r <= op_a[W-1] ^ op_b[W-1];
      if (is_div) begin
        x_r <= mag_a;
        y_r <= mag_b;
        r_r <= '0;
      end else begin
        x_r <= '0;
        y_r <= op_a;
        r_r <= op_b;
      end
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      r_r <= r_nxt;
    end
  end

  assign result = (div_r && neg_r) ? (~x_r + 1'b1) : x_r;
  assign done   = done_r;

endmodule

`default_nettype wire

// ----- hdl/ame_datapath.sv -----
// ----------------------------------------------------------------------------
// ame_datapath
// Accumulator, program counter, halt flag, data memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ame_datapath #(
  parameter int DATA_DEPTH = 32,
  parameter int PROG_DEPTH = 32,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ame_pkg::ame_in_t         in_data,
  input  wire logic [ame_pkg::PC_W-1:0] program_length,
  input  wire ame_pkg::ame_cmd_t        cmd,
  output ame_pkg::ame_sts_t             sts,
  output ame_pkg::ame_out_t             out_data
);

  import ame_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int AW = $clog2(DATA_DEPTH);
  localparam logic [PC_W:0] PROG_LIM = (PC_W + 1)'(PROG_DEPTH);

  logic [CMD_W-1:0]            cmd_r;
  logic [OPERAND_W-1:0]        opd_r;
  logic signed [IO_WORD_W-1:0] rv_r;
  logic [W-1:0]                acc_r, acc_nxt;
  logic [PC_W-1:0]             pc_r;
  logic                        halt_r, halt_nxt;
  ame_out_t                    out_r, out_nxt;

  logic [AW-1:0]  addr_tab [2**OPERAND_W];
  logic [W-1:0]   mem_q, mem_wdata, rv_w, md_result;
  logic           mem_we, md_done, skip;
  logic [PC_W:0]  limit, next_pc;
  logic [63:0]    mem_sx, rv_sx;

  // operand modulo depth, folded at elaboration
  for (genvar g = 0; g < 2**OPERAND_W; g++) begin : g_addr
    assign addr_tab[g] = AW'(g % DATA_DEPTH);
  end

  ame_ram #(
    .WIDTH (W),
    .DEPTH (DATA_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (cmd.commit & mem_we),
    .waddr (addr_tab[opd_r]),
    .wdata (mem_wdata),
    .re    (cmd.load),
    .raddr (addr_tab[in_data.operand]),
    .rdata (mem_q)
  );

  ame_muldiv #(
    .WORD_WIDTH (W)
  ) u_md (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .is_div (cmd_r == OP_DIV),
    .op_a   (acc_r),
    .op_b   (mem_q),
    .result (md_result),
    .done   (md_done)
  );

  assign limit  = ({1'b0, program_length} > PROG_LIM) ? PROG_LIM : {1'b0, program_length};
  assign skip   = halt_r || ({1'b0, pc_r} >= limit);
  assign mem_sx = 64'($signed(mem_q));
  assign rv_sx  = 64'(rv_r);
  assign rv_w   = rv_sx[W-1:0];

  assign sts.need_md = !skip && ((cmd_r == OP_MUL) || ((cmd_r == OP_DIV) && (mem_q != '0)));
  assign sts.md_done = md_done;

  always_comb begin
    next_pc   = {1'b0, pc_r} + 1'b1;
    acc_nxt   = acc_r;
    halt_nxt  = halt_r;
    mem_we    = 1'b0;
    mem_wdata = acc_r;
    out_nxt   = '0;
    if (skip) begin
      halt_nxt = 1'b1;
      next_pc  = {1'b0, pc_r};
    end else begin
      case (cmd_r)
        OP_READ: begin
          mem_we    = 1'b1;
          mem_wdata = rv_w;
        end
        OP_WRITE: begin
          out_nxt.write_valid = 1'b1;
          out_nxt.write_value = mem_sx[IO_WORD_W-1:0];
        end
        OP_LOAD:  acc_nxt = mem_q;
        OP_STORE: mem_we = 1'b1;
        OP_ADD:   acc_nxt = acc_r + mem_q;
        OP_SUB:   acc_nxt = acc_r - mem_q;
        OP_MUL:   acc_nxt = md_result;
        OP_DIV: begin
          if (mem_q == '0) begin
            out_nxt.divide_error = 1'b1;
          end else begin
            acc_nxt = md_result;
          end
        end
        OP_JUMP: next_pc = (PC_W + 1)'(opd_r);
        OP_JNEG: begin
          if (acc_r[W-1]) begin
            next_pc = (PC_W + 1)'(opd_r);
          end
        end
        OP_JZERO: begin
          if (acc_r == '0) begin
            next_pc = (PC_W + 1)'(opd_r);
          end
        end
        OP_HALT: begin
          halt_nxt = 1'b1;
          next_pc  = {1'b0, pc_r};
        end
        default: ;
      endcase
      // running off the end of the program halts at once
      if (!halt_nxt && (next_pc >= limit)) begin
        halt_nxt = 1'b1;
      end
    end
    out_nxt.next_pc = next_pc[PC_W-1:0];
    out_nxt.halted  = halt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pc_r   <= '0;
      halt_r <= 1'b0;
    end else if (cmd.commit) begin
      acc_r  <= acc_nxt;
      pc_r   <= next_pc[PC_W-1:0];
      halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_data.command;
      opd_r <= in_data.operand;
      rv_r  <= in_data.read_value;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !md_done)
    else $error("multiply/divide done still set after start");

endmodule

`default_nettype wire

// ----- hdl/ame_ctrl.sv -----
// ----------------------------------------------------------------------------
// ame_ctrl
// Sequencer: accept an item, execute, wait on multiply/divide, hand off result.
// ----------------------------------------------------------------------------
`default_nettype none

module ame_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ame_pkg::ame_sts_t sts,
  output ame_pkg::ame_cmd_t      cmd
);

  import ame_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ITER
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cmd.load      = accept;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.need_md) begin
          cmd.start = 1'b1;
          state_nxt = ST_ITER;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_ITER: begin
        if (sts.md_done && out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted item did not enter execute");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken item");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("committed result not presented");

endmodule

`default_nettype wire

// ----- hdl/accumulator_machine_execute.sv -----
// ----------------------------------------------------------------------------
// accumulator_machine_execute
// Execute unit of a small accumulator machine with an APB program-length reg.
// ----------------------------------------------------------------------------
// Sequence: the accepting edge latches the item and reads data memory; the
//   commit then registers the result and raises out_valid. MUL and a
//   nonzero-divisor DIV first run the one-bit-per-cycle multiply/divide.
// A new item is accepted only once the previous one has committed.
// An untaken result lets the next item in, but holds its commit until taken.
// Reset (rst_n low, synchronous) clears acc, pc, halt flag and program_length.
`default_nettype none

module accumulator_machine_execute #(
  parameter int DATA_DEPTH = 32,
  parameter int PROG_DEPTH = 32,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ame_pkg::ame_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ame_pkg::ame_out_t      out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  import ame_pkg::*;

  ame_cmd_t        cmd;
  ame_sts_t        sts;
  logic [PC_W-1:0] plen_r;
  logic            sel_plen;

  assign pready   = 1'b1;
  assign sel_plen = (paddr[2] == REG_PROGRAM_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
    end else if (psel && penable && pwrite && sel_plen) begin
      plen_r <= pwdata[PC_W-1:0];
    end
  end

  assign prdata = sel_plen ? {{(32 - PC_W){1'b0}}, plen_r} : '0;

  ame_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ame_datapath #(
    .DATA_DEPTH (DATA_DEPTH),
    .PROG_DEPTH (PROG_DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data        (in_data),
    .program_length (plen_r),
    .cmd            (cmd),
    .sts            (sts),
    .out_data       (out_data)
  );

endmodule

`default_nettype wire
